// ===== rtl/core/bfc_pkg.sv =====
`default_nettype none

package bfc_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int PIX_W     = 8;
    localparam int WCFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int COLSUM_W  = PIX_W + 2;
    localparam int SUM_W     = PIX_W + 4;

    // (sum + 4) / 9 as ((sum + 4) * RECIP_9) >> RECIP_SHIFT, exact for sums below 2^12
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2 ** RECIP_SHIFT + 8) / 9);
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [COL_W-1:0] RESET_LAST_COL = COL_W'(640 - 1);
    localparam logic [ROW_W-1:0] RESET_LAST_ROW = ROW_W'(480 - 1);
    localparam int MIN_DIM = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    typedef logic [PIX_W-1:0]    pixel_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [COLSUM_W-1:0] colsum_t;

    typedef struct packed {
        logic wr_en;
        col_t wr_addr;
        logic rd_en;
        col_t rd_addr;
    } store_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/box_filter_3x3_stream.sv =====
`default_nettype none

// channel  | group          | payload (low bit up)
// ---------+----------------+-----------------------------------------
// pixels   | s_t*           | tdata[7:0] pixel
// results  | m_t*           | tdata[7:0] mean_pixel, tlast last_in_frame
// config   | cfg_*          | index 0 frame_width, 1 frame_height
//
// One pixel per cycle while the result side is ready; a result passes in turn the
// line store read register, column-sum cells and divide-by-nine multiplier.
// Border pixels cause no transfer on the result side.
// Reset restores 640x480 and zeros the window; line stores hold no reset value.
// Stalls on the result side back up through the three stages to s_tready.
module box_filter_3x3_stream (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bfc_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bfc_pkg::PIX_W-1:0]          m_tdata,   // [7:0] mean_pixel
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import bfc_pkg::*;

    col_t             last_col_reg;
    logic [ROW_W-1:0] last_row_reg;
    col_t             col_reg;
    logic [ROW_W-1:0] row_reg;

    logic             s1_valid_reg;
    logic             s1_prod_reg;
    logic             s1_last_reg;
    col_t             s1_addr_reg;
    pixel_t           s1_pix_reg;

    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [SUM_W-1:0] s2_sum_reg;

    logic             out_valid_reg;
    logic             out_last_reg;
    pixel_t           out_mean_reg;

    logic             accept;
    logic             cfg_wr;
    logic             cfg_hit;
    logic             out_free;
    logic             s2_free;
    logic             s1_adv;
    logic             at_last_col;
    logic             at_last_row;
    logic [WCFG_W-1:0] w_cfg;
    col_t             w_last;
    logic [ROW_W-1:0] h_last;

    store_ctrl_t      st_ctrl;
    pixel_t           top_pix;
    pixel_t           mid_pix;
    colsum_t          colsum;
    colsum_t          cell_new;
    colsum_t          cell_old;
    logic [SUM_W-1:0] total;
    logic [PROD_W-1:0] prod;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT);

    assign w_cfg  = cfg_data[WCFG_W-1:0];
    assign w_last = (w_cfg < WCFG_W'(MIN_DIM)) ? col_t'(MIN_DIM - 1)
                  : (w_cfg > WCFG_W'(MAX_WIDTH)) ? col_t'(MAX_WIDTH - 1)
                  : col_t'(w_cfg - WCFG_W'(1));
    assign h_last = (cfg_data < CFG_DAT_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1)
                  : ROW_W'(cfg_data - CFG_DAT_W'(1));

    assign out_free = !out_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;
    assign accept   = s_tvalid && s_tready;

    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    assign st_ctrl.wr_en   = s1_adv;
    assign st_ctrl.wr_addr = s1_addr_reg;
    assign st_ctrl.rd_en   = accept;
    assign st_ctrl.rd_addr = col_reg;

    bfc_line_store u_store_upper (
        .clk     (clk),
        .ctrl    (st_ctrl),
        .wr_data (mid_pix),
        .rd_data (top_pix)
    );

    bfc_line_store u_store_middle (
        .clk     (clk),
        .ctrl    (st_ctrl),
        .wr_data (s1_pix_reg),
        .rd_data (mid_pix)
    );

    assign colsum = colsum_t'(top_pix) + colsum_t'(mid_pix) + colsum_t'(s1_pix_reg);

    bfc_cell u_cell_new (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_adv),
        .din      (colsum),
        .dout     (cell_new)
    );

    bfc_cell u_cell_old (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_adv),
        .din      (cell_new),
        .dout     (cell_old)
    );

    assign total = SUM_W'(cell_old) + SUM_W'(cell_new) + SUM_W'(colsum);
    assign prod  = PROD_W'(s2_sum_reg + SUM_W'(4)) * PROD_W'(RECIP_9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= RESET_LAST_COL;
            last_row_reg  <= RESET_LAST_ROW;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && cfg_hit)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                begin
                    last_col_reg <= w_last;
                end
                else
                begin
                    last_row_reg <= h_last;
                end
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (at_last_col)
                begin
                    col_reg <= '0;
                    row_reg <= at_last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + col_t'(1);
                end
            end

            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv && s1_prod_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= s_tdata;
            s1_addr_reg <= col_reg;
            s1_prod_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= col_t'(2));
            s1_last_reg <= at_last_col && at_last_row;
        end
        if (s2_free && s1_adv)
        begin
            s2_sum_reg  <= total;
            s2_last_reg <= s1_last_reg;
        end
        if (out_free && s2_valid_reg)
        begin
            out_mean_reg <= prod[RECIP_SHIFT +: PIX_W];
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mean_reg;
    assign m_tlast  = out_last_reg;

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && cfg_hit |=> col_reg == '0 && row_reg == '0)
        else $error("frame counters not cleared by register write");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col_reg)
        else $error("column counter past row end");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_wr && at_last_col && at_last_row |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap at frame end");

    a_s2_only_results: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_prod_reg))
        else $error("border pixel entered result stage");

endmodule

`default_nettype wire

// ===== rtl/core/bfc_line_store.sv =====
`default_nettype none

module bfc_line_store (
    input  wire logic                 clk,
    input  wire bfc_pkg::store_ctrl_t ctrl,
    input  wire bfc_pkg::pixel_t      wr_data,
    output bfc_pkg::pixel_t           rd_data
);
    import bfc_pkg::*;

    pixel_t mem [MAX_WIDTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bfc_cell.sv =====
`default_nettype none

module bfc_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift_en,
    input  wire bfc_pkg::colsum_t din,
    output bfc_pkg::colsum_t      dout
);
    import bfc_pkg::*;

    colsum_t sum_reg;
    colsum_t sum_next;

    assign sum_next = shift_en ? din : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign dout = sum_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bfc_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PIXELS = 1950;
    localparam int MAX_REPORTS   = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum int {PACE_FULL, PACE_BUSY, PACE_SPARSE} pace_t;
    typedef enum int {TONE_NOISE, TONE_EXTREME, TONE_DIM} tone_t;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             last;
    } window_mean_t;

    class box_mean_board;
        pixel_t       upper_row [MAX_WIDTH];
        pixel_t       middle_row [MAX_WIDTH];
        pixel_t       win [6];
        int           col;
        int           row;
        int           width_reg;
        int           height_reg;
        int           errors;
        window_mean_t means_due [$];

        function new();
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col        = 0;
            row        = 0;
            width_reg  = 640;
            height_reg = 480;
            errors     = 0;
        endfunction

        function int cols();
            if (width_reg < MIN_DIM)
                return MIN_DIM;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int rows();
            return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        endfunction

        function int outstanding();
            return means_due.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = int'(val[WCFG_W-1:0]);
                CFG_FRAME_HEIGHT: height_reg = int'(val);
                default:          return;
            endcase
            // restart the frame
            col = 0;
            row = 0;
        endfunction

        function void note_pixel(pixel_t px);
            int           w;
            int           h;
            int           c;
            int           r;
            int           sum;
            pixel_t       top;
            pixel_t       mid;
            window_mean_t due;
            w   = cols();
            h   = rows();
            c   = (col >= w) ? w - 1 : col;
            r   = (row >= h) ? h - 1 : row;
            top = upper_row[c];
            mid = middle_row[c];
            if (r >= 2 && c >= 2)
            begin
                sum = int'(top) + int'(mid) + int'(px);
                foreach (win[k])
                    sum += int'(win[k]);
                due.mean = PIX_W'((sum + 4) / 9);
                due.last = (r == h - 1) && (c == w - 1);
                means_due.push_back(due);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = px;
            upper_row[c]  = mid;
            middle_row[c] = px;
            if (c == w - 1)
            begin
                col = 0;
                row = (r == h - 1) ? 0 : r + 1;
            end
            else
            begin
                col = c + 1;
                row = r;
            end
        endfunction

        function void check_mean(pixel_t got, logic got_last);
            window_mean_t due;
            if (means_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual mean %0d last %0b",
                             $time, got, got_last);
                return;
            end
            due = means_due.pop_front();
            if (got !== due.mean)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mean_pixel expected %0d actual %0d", $time, due.mean, got);
            end
            if (got_last !== due.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: last_in_frame expected %0b actual %0b",
                             $time, due.last, got_last);
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    pixel_t               s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    pixel_t               m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    pace_t         feed_pace = PACE_FULL;
    pace_t         sink_pace = PACE_FULL;
    int            cycles    = 0;
    box_mean_board board;

    box_filter_3x3_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(pace_t pace);
        case (pace)
            PACE_FULL: return 0;
            PACE_BUSY: return $urandom_range(0, 13);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic pixel_t draw_pixel(tone_t tone);
        case (tone)
            TONE_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            TONE_DIM:     return PIX_W'($urandom_range(0, 3));
            default:      return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input pixel_t px);
        int   gap;
        logic taken;
        gap = draw_gap(feed_pace);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            if (taken)
                board.note_pixel(px);
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the pixel side until every pending mean has arrived and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int     gap;
        logic   seen;
        pixel_t got;
        logic   got_last;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(sink_pace);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                seen     = m_tvalid;
                got      = m_tdata;
                got_last = m_tlast;
                @(posedge clk);
            end while (!seen);
            board.check_mean(got, got_last);
        end
    end

    initial
    begin : stimulus
        pixel_t                      rounding_frame [12];
        int                          done;
        int                          n;
        int                          pause_at;
        bit                          paused;
        tone_t                       tone;
        logic [WCFG_W-1:0]           w_val;
        logic [CFG_DAT_W-1:0]        h_val;
        logic [CFG_DAT_W-WCFG_W-1:0] spare;
        rounding_frame = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd4, 8'd0,
                           8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(CFG_SPARE_2, 16'hFFFF);
        write_cfg(CFG_FRAME_WIDTH, 16'hF801);
        write_cfg(CFG_FRAME_HEIGHT, 16'h0000);
        repeat (9) send_pixel(8'hFF);
        repeat (4) send_pixel(8'h80);
        settle();
        write_cfg(CFG_FRAME_HEIGHT, 16'd4);
        foreach (rounding_frame[i])
            send_pixel(rounding_frame[i]);
        settle();

        feed_pace = PACE_SPARSE;
        sink_pace = PACE_SPARSE;
        write_cfg(CFG_FRAME_HEIGHT, 16'hFFFF);
        write_cfg(CFG_FRAME_WIDTH, 16'hFFFF);
        repeat (2 * MAX_WIDTH + 12) send_pixel(PIX_W'($urandom));
        settle();

        done   = 0;
        paused = 1'b0;
        while (done < RANDOM_PIXELS)
        begin
            feed_pace = pace_t'($urandom_range(0, 2));
            sink_pace = pace_t'($urandom_range(0, 2));
            tone      = tone_t'($urandom_range(0, 2));
            spare     = (CFG_DAT_W-WCFG_W)'($urandom_range(0, 31));
            case ($urandom_range(0, 9))
                0:       w_val = WCFG_W'($urandom_range(0, 2));
                1:       w_val = WCFG_W'($urandom_range(13, 64));
                default: w_val = WCFG_W'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       h_val = CFG_DAT_W'($urandom_range(0, 2));
                1:       h_val = CFG_DAT_W'($urandom_range(7, 65535));
                default: h_val = CFG_DAT_W'($urandom_range(3, 6));
            endcase
            case ($urandom_range(0, 5))
                0: write_cfg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                             CFG_DAT_W'($urandom));
                1: write_cfg(CFG_FRAME_WIDTH, {spare, w_val});
                2: write_cfg(CFG_FRAME_HEIGHT, h_val);
                3:
                begin
                    write_cfg(CFG_FRAME_HEIGHT, h_val);
                    write_cfg(CFG_FRAME_WIDTH, {spare, w_val});
                end
                default:
                begin
                    write_cfg(CFG_FRAME_WIDTH, {spare, w_val});
                    write_cfg(CFG_FRAME_HEIGHT, h_val);
                end
            endcase

            if (board.rows() > 6 || board.cols() > 12)
                n = board.cols() * $urandom_range(3, 6);
            else
                n = board.cols() * board.rows() * $urandom_range(1, 3);
            // cut some phases mid-frame
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 2 * board.cols());

            if (!paused)
                pause_at = n / 2;
            else if ($urandom_range(0, 5) == 0)
                pause_at = $urandom_range(0, n - 1);
            else
                pause_at = -1;

            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    settle();
                send_pixel(draw_pixel(tone));
            end
            paused = 1'b1;
            done += n;
            settle();
        end

        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bfc_pkg.sv
rtl/core/bfc_line_store.sv
rtl/core/bfc_cell.sv
rtl/core/box_filter_3x3_stream.sv
tb/sv/testbench.sv
